// File: rtl/core/foc_pkg.sv
`timescale 1ns / 1ps

package foc_pkg;

  // Field layout of the stream
  localparam int FIELD_W           = 32;
  localparam int COORD_W           = 32;
  localparam int IN_DATA_W         = 6 * FIELD_W;
  localparam int OUT_DATA_W        = 8;
  localparam int STATUS_W          = 2;

  // Face bounds
  localparam int MAX_FACE_VERTICES = 64;
  localparam int MIN_FACE_VERTICES = 3;
  localparam int NUM_AXES          = 3;
  localparam int CNT_W             = $clog2(MAX_FACE_VERTICES + 1);

  // Arithmetic widths
  localparam int SUM_W  = COORD_W + CNT_W;       // running coordinate sum
  localparam int DIF_W  = COORD_W + 1;           // edge vector p1-p0, p2-p0
  localparam int MUL_W  = COORD_W + 2;           // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int NRM_W  = 2 * DIF_W + 1;         // normal component
  localparam int NLO_W  = MUL_W - 1;             // unsigned low part of a normal
  localparam int D_W    = SUM_W + 1;             // sum - count * centroid
  localparam int DLO_W  = D_W / 2;               // unsigned low part of an offset
  localparam int DHI_W  = D_W - DLO_W;
  localparam int ACC_W  = NRM_W + D_W + 2;       // dot product

  // Multiply schedule: offsets, then cross terms, then dot partial products
  localparam int STEP_CROSS = NUM_AXES;
  localparam int STEP_DOT   = STEP_CROSS + 2 * NUM_AXES;
  localparam int NUM_STEPS  = STEP_DOT + 4 * NUM_AXES;
  localparam int STEP_W     = $clog2(NUM_STEPS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [DIF_W-1:0]   dif_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [NRM_W-1:0]   nrm_t;
  typedef logic signed [D_W-1:0]     ofs_t;
  typedef logic signed [DHI_W-1:0]   ofs_hi_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [1:0]                axis_t;
  typedef logic [STEP_W-1:0]         step_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_LONG  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OPA_COUNT = 2'd0,
    OPA_DIFF  = 2'd1,
    OPA_NLO   = 2'd2,
    OPA_NHI   = 2'd3
  } opa_e;

  typedef enum logic [1:0] {
    OPB_CENT = 2'd0,
    OPB_DIFF = 2'd1,
    OPB_DLO  = 2'd2,
    OPB_DHI  = 2'd3
  } opb_e;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_OFS  = 3'd1,
    WB_TMP  = 3'd2,
    WB_NRM  = 3'd3,
    WB_DOT  = 3'd4
  } wb_e;

  // Order follows the partial product index: bit 0 offset high, bit 1 normal high
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_D    = 2'd1,
    SH_N    = 2'd2,
    SH_ND   = 2'd3
  } sh_e;

  typedef struct packed {
    opa_e  a_kind;
    axis_t a_axis;
    opb_e  b_kind;
    axis_t b_axis;
    wb_e   wb;
    axis_t wb_axis;
    sh_e   sh;
  } mul_cmd_t;

  localparam mul_cmd_t MUL_IDLE = '{
    a_kind: OPA_COUNT, a_axis: 2'd0, b_kind: OPB_CENT, b_axis: 2'd0,
    wb: WB_NONE, wb_axis: 2'd0, sh: SH_NONE
  };

  typedef struct packed {
    logic     push;
    logic     prep;
    logic     clear;
    mul_cmd_t mul;
  } dp_cmd_t;

  typedef struct packed {
    logic long_face;
    logic short_face;
    logic neg;
  } dp_stat_t;

  typedef struct packed {
    logic    load;
    logic    flip;
    status_e status;
  } res_t;

  // One multiply of the face-end schedule
  function automatic mul_cmd_t step_cmd(input step_t step);
    mul_cmd_t c;
    step_t    idx;
    c   = MUL_IDLE;
    idx = step - step_t'(STEP_DOT);
    if (step < step_t'(STEP_CROSS)) begin
      c.a_kind  = OPA_COUNT;
      c.b_kind  = OPB_CENT;
      c.a_axis  = step[1:0];
      c.b_axis  = step[1:0];
      c.wb      = WB_OFS;
      c.wb_axis = step[1:0];
    end else if (step < step_t'(STEP_DOT)) begin
      c.a_kind = OPA_DIFF;
      c.b_kind = OPB_DIFF;
      c.wb     = step[0] ? WB_TMP : WB_NRM;
      unique case (step)
        step_t'(STEP_CROSS + 0): begin c.a_axis = 2'd1; c.b_axis = 2'd2; c.wb_axis = 2'd0; end
        step_t'(STEP_CROSS + 1): begin c.a_axis = 2'd2; c.b_axis = 2'd1; c.wb_axis = 2'd0; end
        step_t'(STEP_CROSS + 2): begin c.a_axis = 2'd2; c.b_axis = 2'd0; c.wb_axis = 2'd1; end
        step_t'(STEP_CROSS + 3): begin c.a_axis = 2'd0; c.b_axis = 2'd2; c.wb_axis = 2'd1; end
        step_t'(STEP_CROSS + 4): begin c.a_axis = 2'd0; c.b_axis = 2'd1; c.wb_axis = 2'd2; end
        default:                 begin c.a_axis = 2'd1; c.b_axis = 2'd0; c.wb_axis = 2'd2; end
      endcase
    end else if (step < step_t'(NUM_STEPS)) begin
      c.a_kind  = idx[1] ? OPA_NHI : OPA_NLO;
      c.b_kind  = idx[0] ? OPB_DHI : OPB_DLO;
      c.a_axis  = idx[3:2];
      c.b_axis  = idx[3:2];
      c.wb      = WB_DOT;
      c.wb_axis = idx[3:2];
      c.sh      = sh_e'(idx[1:0]);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/foc_mul.sv
`timescale 1ns / 1ps

module foc_mul (
  input  logic             clk_i,
  input  foc_pkg::mul_op_t a_i,
  input  foc_pkg::mul_op_t b_i,
  output foc_pkg::prod_t   prod_o
);
  import foc_pkg::*;

  prod_t prod_q;

  // Signed product, registered before any use
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/foc_dp.sv
`timescale 1ns / 1ps

module foc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  foc_pkg::dp_cmd_t  cmd_i,
  input  foc_pkg::coord_t   vtx_i  [foc_pkg::NUM_AXES],
  input  foc_pkg::coord_t   cell_i [foc_pkg::NUM_AXES],
  output foc_pkg::dp_stat_t stat_o
);
  import foc_pkg::*;

  sum_t     sum_q [NUM_AXES];
  cnt_t     cnt_q;
  logic     ovf_q;
  coord_t   p_q   [NUM_AXES][NUM_AXES];
  coord_t   c_q   [NUM_AXES];
  dif_t     a_q   [NUM_AXES];
  dif_t     b_q   [NUM_AXES];
  ofs_t     d_q   [NUM_AXES];
  nrm_t     n_q   [NUM_AXES];
  nrm_t     t_q;
  acc_t     acc_q;
  mul_cmd_t wb_q;
  mul_op_t  mul_a;
  mul_op_t  mul_b;
  prod_t    prod;
  acc_t     pp;
  logic     full;

  assign full = (cnt_q >= cnt_t'(MAX_FACE_VERTICES));

  // Face accumulation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_AXES; k++) sum_q[k] <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      for (int k = 0; k < NUM_AXES; k++) sum_q[k] <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.push) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        for (int k = 0; k < NUM_AXES; k++) sum_q[k] <= sum_q[k] + SUM_W'(vtx_i[k]);
        cnt_q <= cnt_q + cnt_t'(1);
      end
    end
  end

  // First three vertices and the centroid of the latest item
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      for (int k = 0; k < NUM_AXES; k++) c_q[k] <= cell_i[k];
      for (int v = 0; v < NUM_AXES; v++) begin
        if (!full && cnt_q == cnt_t'(v)) begin
          for (int k = 0; k < NUM_AXES; k++) p_q[v][k] <= vtx_i[k];
        end
      end
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    unique case (cmd_i.mul.a_kind)
      OPA_COUNT: mul_a = mul_op_t'({{(MUL_W - CNT_W){1'b0}}, cnt_q});
      OPA_DIFF:  mul_a = MUL_W'(a_q[cmd_i.mul.a_axis]);
      OPA_NLO:   mul_a = mul_op_t'({1'b0, n_q[cmd_i.mul.a_axis][NLO_W-1:0]});
      OPA_NHI:   mul_a = mul_op_t'(n_q[cmd_i.mul.a_axis][NRM_W-1:NLO_W]);
    endcase
    unique case (cmd_i.mul.b_kind)
      OPB_CENT: mul_b = MUL_W'(c_q[cmd_i.mul.b_axis]);
      OPB_DIFF: mul_b = MUL_W'(b_q[cmd_i.mul.b_axis]);
      OPB_DLO:  mul_b = mul_op_t'({{(MUL_W - DLO_W){1'b0}},
                                   d_q[cmd_i.mul.b_axis][DLO_W-1:0]});
      OPB_DHI:  mul_b = MUL_W'(ofs_hi_t'(d_q[cmd_i.mul.b_axis][D_W-1:DLO_W]));
    endcase
  end

  foc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Write-back command is registered alongside the product, so both line up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= MUL_IDLE;
    end else begin
      wb_q <= cmd_i.mul;
    end
  end

  always_comb begin
    pp = ACC_W'(prod);
    unique case (wb_q.sh)
      SH_NONE: pp = pp;
      SH_D:    pp = pp <<< DLO_W;
      SH_N:    pp = pp <<< NLO_W;
      SH_ND:   pp = pp <<< (NLO_W + DLO_W);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        a_q[k] <= DIF_W'(p_q[1][k]) - DIF_W'(p_q[0][k]);
        b_q[k] <= DIF_W'(p_q[2][k]) - DIF_W'(p_q[0][k]);
      end
      acc_q <= '0;
    end else begin
      unique case (wb_q.wb)
        WB_NONE: ;
        WB_OFS:  d_q[wb_q.wb_axis] <= D_W'(sum_q[wb_q.wb_axis]) - D_W'(prod);
        WB_TMP:  t_q <= NRM_W'(prod);
        WB_NRM:  n_q[wb_q.wb_axis] <= t_q - NRM_W'(prod);
        WB_DOT:  acc_q <= acc_q + pp;
        default: ;
      endcase
    end
  end

  assign stat_o.long_face  = ovf_q;
  assign stat_o.short_face = (cnt_q < cnt_t'(MIN_FACE_VERTICES));
  assign stat_o.neg        = acc_q[ACC_W-1];

endmodule

// File: rtl/core/foc_ctrl.sv
`timescale 1ns / 1ps

module foc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              s_last_i,
  input  logic              out_free_i,
  input  foc_pkg::dp_stat_t stat_i,
  output logic              s_ready_o,
  output foc_pkg::dp_cmd_t  cmd_o,
  output foc_pkg::res_t     res_o
);
  import foc_pkg::*;

  localparam logic [2:0] ST_ACCUM  = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_CALC   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  step_t      step_q, step_d;
  status_e    status_q, status_d;
  logic       push;

  assign s_ready_o = (state_q == ST_ACCUM);
  assign push      = s_ready_o && s_valid_i;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    status_d     = status_q;
    cmd_o.push   = push;
    cmd_o.prep   = 1'b0;
    cmd_o.clear  = 1'b0;
    cmd_o.mul    = MUL_IDLE;
    res_o.load   = 1'b0;
    res_o.flip   = (status_q == STATUS_OK) && stat_i.neg;
    res_o.status = status_q;
    unique case (state_q)
      ST_ACCUM: begin
        if (push && s_last_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        if (stat_i.long_face) begin
          status_d = STATUS_LONG;
          state_d  = ST_FINISH;
        end else if (stat_i.short_face) begin
          status_d = STATUS_SHORT;
          state_d  = ST_FINISH;
        end else begin
          status_d = STATUS_OK;
          state_d  = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.mul = step_cmd(step_q);
        if (step_q == step_t'(NUM_STEPS - 1)) state_d = ST_DRAIN;
        else step_d = step_q + step_t'(1);
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          res_o.load  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_ACCUM;
      step_q   <= '0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      status_q <= status_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.load |-> out_free_i)
    else $error("result loaded over a waiting result");

  a_last_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && s_last_i) |=> (state_q == ST_CHECK))
    else $error("last vertex did not start the face check");

  a_drain_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |->
      ($past(state_q) == ST_CALC && $past(step_q) == step_t'(NUM_STEPS - 1)))
    else $error("drain entered before the multiply schedule finished");

  a_mul_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mul.wb != WB_NONE) |-> !s_ready_o)
    else $error("multiply issued while vertices are accepted");

endmodule

// File: rtl/core/face_orientation_check.sv
// Vertices are taken one per cycle while a face accumulates; an unmarked vertex
// gives no result. After its last vertex, a face passes a check state, 21 products
// through the shared 34x34 multiplier and a drain state; its result is then loaded
// once the output register is free. A short or long face goes from the check straight
// to the load. No vertex of the next face is taken until the result is loaded.
// Reset (rst_ni low, asynchronous) clears control, sums, count and output valid.
`timescale 1ns / 1ps

module face_orientation_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // vertex_x, vertex_y, vertex_z, cell_x, cell_y, cell_z (32 bits each, lowest first)
  input  logic [foc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tlast,   // last_vertex
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // flip in bit 0, zero above
  output logic [foc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status
  output logic [foc_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import foc_pkg::*;

  coord_t   vtx  [NUM_AXES];
  coord_t   cent [NUM_AXES];
  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;
  logic     out_free;
  logic     out_valid_q;
  logic     flip_q;
  status_e  status_q;

  // Unpack the vertex and the owner centroid from the item
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      vtx[k]  = s_axis_tdata[k * FIELD_W +: COORD_W];
      cent[k] = s_axis_tdata[(k + NUM_AXES) * FIELD_W +: COORD_W];
    end
  end

  // The output register frees as soon as the waiting item is taken
  assign out_free = !out_valid_q || m_axis_tready;

  foc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_last_i   (s_axis_tlast),
    .out_free_i (out_free),
    .stat_i     (stat),
    .s_ready_o  (s_axis_tready),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  foc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .vtx_i  (vtx),
    .cell_i (cent),
    .stat_o (stat)
  );

  // Hold the result until the sink takes it; next face keeps streaming meanwhile
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      flip_q   <= res.flip;
      status_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, flip_q};
  assign m_axis_tuser  = status_q;

endmodule
